### rtl/dth_pkg.sv
// Shared types and the header classification function for the DER header encoder.
package dth_pkg;

  localparam int MaxBytes = 8;
  localparam logic [31:0] TagMax      = 32'h0000_3fff;
  localparam logic [31:0] TagShortLim = 32'd31;
  localparam logic [31:0] TagOneByte  = 32'h0000_007f;
  localparam logic [31:0] LenShortLim = 32'd128;
  localparam logic [7:0]  TagEscape   = 8'h1f;
  localparam logic [7:0]  LongForm    = 8'h80;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] hdr;    // header bytes, index 0 sent first
    logic [3:0]               cnt;    // 1..8
    logic                     err;
    logic [32:0]              total;
  } desc_t;

  function automatic desc_t classify(input logic [1:0]  cls,
                                     input logic        cons,
                                     input logic [31:0] tag,
                                     input logic [31:0] vlen);
    desc_t      d;
    logic [7:0] first;
    logic [7:0] id [4];
    logic [7:0] lb [8];
    logic [2:0] nid;
    logic [2:0] nlen;
    logic [2:0] vcnt;
    logic [2:0] j;
    first = {cls, cons, 5'd0};
    for (int k = 0; k < 4; k++) id[k] = 8'd0;
    for (int k = 0; k < 8; k++) lb[k] = 8'd0;
    id[0] = first | {3'd0, tag[4:0]};
    nid   = 3'd1;
    if (tag >= TagShortLim) begin
      id[0] = first | TagEscape;
      if (tag <= TagOneByte) begin
        id[1] = {1'b0, tag[6:0]};
        nid   = 3'd2;
      end else begin
        // continuation bit on the leading base-128 digit
        id[1] = {1'b1, tag[13:7]};
        id[2] = {1'b0, tag[6:0]};
        nid   = 3'd3;
      end
    end
    if (vlen[31:24] != 8'd0)      vcnt = 3'd4;
    else if (vlen[23:16] != 8'd0) vcnt = 3'd3;
    else if (vlen[15:8] != 8'd0)  vcnt = 3'd2;
    else                          vcnt = 3'd1;
    if (vlen < LenShortLim) begin
      lb[0] = vlen[7:0];
      nlen  = 3'd1;
    end else begin
      lb[0] = LongForm | {5'd0, vcnt};
      nlen  = vcnt + 3'd1;
      case (vcnt)
        3'd4: begin
          lb[1] = vlen[31:24]; lb[2] = vlen[23:16]; lb[3] = vlen[15:8]; lb[4] = vlen[7:0];
        end
        3'd3: begin
          lb[1] = vlen[23:16]; lb[2] = vlen[15:8]; lb[3] = vlen[7:0];
        end
        3'd2: begin
          lb[1] = vlen[15:8]; lb[2] = vlen[7:0];
        end
        default: lb[1] = vlen[7:0];
      endcase
    end
    for (int i = 0; i < MaxBytes; i++) begin
      j = 3'(i) - nid;
      if (3'(i) < nid) d.hdr[i] = id[2'(i)];
      else             d.hdr[i] = lb[j];
    end
    d.cnt   = {1'b0, nid} + {1'b0, nlen};
    d.err   = 1'b0;
    d.total = {1'b0, vlen} + {29'd0, d.cnt};
    if (tag > TagMax) begin
      d.hdr   = '0;
      d.cnt   = 4'd1;
      d.err   = 1'b1;
      d.total = 33'd0;
    end
    return d;
  endfunction

endpackage

### rtl/dth_front.sv
// Front end: accepts input items, classifies them into header descriptors.
module dth_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_tag_class,
  input  logic              in_constructed,
  input  logic [31:0]       in_tag_number,
  input  logic [31:0]       in_value_length,
  output logic              push,
  output dth_pkg::desc_t    push_data,
  input  logic              q_full
);

  logic           fv_r;
  dth_pkg::desc_t fd_r;
  logic           adv;

  assign push      = fv_r && !q_full;
  assign adv       = !fv_r || push;
  assign in_stall  = !adv;
  assign push_data = fd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      if (adv) fv_r <= in_valid;
      if (adv && in_valid) begin
        fd_r <= dth_pkg::classify(in_tag_class, in_constructed,
                                  in_tag_number, in_value_length);
      end
    end
  end

endmodule

### rtl/dth_queue.sv
// Two-entry descriptor queue between front end and byte emitter.
module dth_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dth_pkg::desc_t push_data,
  output logic           q_full,
  input  logic           pop,
  output logic           q_valid,
  output dth_pkg::desc_t q_data
);

  dth_pkg::desc_t mem [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/dth_back.sv
// Back end: walks a descriptor and emits one header byte per cycle while out_stall is low.
module dth_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  dth_pkg::desc_t q_data,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_header_byte,
  output logic           out_last_byte,
  output logic           out_tag_error,
  output logic [32:0]    out_total_length
);

  logic           out_valid_r;
  logic [7:0]     byte_r;
  logic           last_r;
  logic           err_r;
  logic [32:0]    total_r;
  logic           cur_valid_r;
  dth_pkg::desc_t cur_r;
  logic [2:0]     idx_r;
  logic           adv;
  logic           emit;
  logic           is_last;
  logic           done;

  assign adv     = !out_valid_r || !out_stall;
  assign emit    = cur_valid_r && adv;
  assign is_last = ({1'b0, idx_r} == (cur_r.cnt - 4'd1));
  assign done    = emit && is_last;
  // refill on the last byte so items run back to back
  assign pop     = q_valid && (!cur_valid_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      if (adv) out_valid_r <= cur_valid_r;
      if (emit) begin
        byte_r  <= cur_r.hdr[idx_r];
        last_r  <= is_last;
        err_r   <= cur_r.err;
        total_r <= is_last ? cur_r.total : 33'd0;
      end
      if (pop) begin
        idx_r <= 3'd0;
      end else if (emit) begin
        idx_r <= idx_r + 3'd1;
      end
      if (pop) begin
        cur_r       <= q_data;
        cur_valid_r <= 1'b1;
      end else if (done) begin
        cur_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_header_byte  = byte_r;
  assign out_last_byte    = last_r;
  assign out_tag_error    = err_r;
  assign out_total_length = total_r;

endmodule

### rtl/der_tag_length_header_encoder_core.sv
// Top level of the DER identifier/length header encoder.
// Input channel (in_*): one item per ASN.1 element - class, constructed flag,
// tag number and value length. Accepted when in_valid is high and in_stall low.
// Result channel (out_*): the DER header bytes of each item, one per cycle while
// out_stall is low, in transmission order. out_last_byte marks the final byte,
// which also carries out_total_length (header bytes plus value length). A tag
// above 16383 yields a single zero byte with out_tag_error and out_last_byte set.
// The first byte of an item passes the front register, the descriptor queue,
// the current-descriptor register and the output register.
// The header bytes of an item (1 to 8) leave one at a time through the single
// byte-wide output register; while the queue holds the next descriptor, items
// follow one another with no gap cycles.
// When out_stall is high the output register holds; the queue and the front
// register absorb up to three further items before in_stall rises.
// Reset (rst_n low, synchronous) empties every stage; no items are pending.
module der_tag_length_header_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_tag_class,
  input  logic        in_constructed,
  input  logic [31:0] in_tag_number,
  input  logic [31:0] in_value_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_header_byte,
  output logic        out_last_byte,
  output logic        out_tag_error,
  output logic [32:0] out_total_length
);

  logic           push;
  logic           q_full;
  logic           pop;
  logic           q_valid;
  dth_pkg::desc_t push_data;
  dth_pkg::desc_t q_data;

  dth_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tag_class    (in_tag_class),
    .in_constructed  (in_constructed),
    .in_tag_number   (in_tag_number),
    .in_value_length (in_value_length),
    .push            (push),
    .push_data       (push_data),
    .q_full          (q_full)
  );

  dth_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  dth_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_header_byte  (out_header_byte),
    .out_last_byte    (out_last_byte),
    .out_tag_error    (out_tag_error),
    .out_total_length (out_total_length)
  );

  // an error item is always a lone zero byte
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tag_error |-> out_last_byte && out_header_byte == 8'd0)
    else $error("tag error result not a single zero byte");

  a_total_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_byte |-> out_total_length == 33'd0)
    else $error("total length on a non-final byte");

  // total covers at least the header bytes
  a_total_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte && !out_tag_error |-> out_total_length >= 33'd2)
    else $error("total length below minimum header size");

endmodule

### tb/sv/dth_tb_pkg.sv
// Scoreboard for the DER header encoder bench: predicted header bytes and their checks.
package dth_tb_pkg;

  typedef struct packed {
    logic [7:0]  hdr_byte;
    logic        last;
    logic        err;
    logic [32:0] total;
  } hdr_byte_t;

  class der_header_scoreboard;
    hdr_byte_t   expected_bytes[$];
    int unsigned elements_seen;
    int unsigned oversized_tags;
    int unsigned bytes_checked;
    int unsigned mismatches;

    // Predict the header bytes of one accepted element and queue them.
    function void note_element(logic [1:0] cls, logic cons, logic [31:0] tag,
                               logic [31:0] vlen);
      logic [7:0] hdr[$];
      logic [7:0] id0;
      hdr_byte_t  r;
      int         nlen;
      elements_seen++;
      if (tag > dth_pkg::TagMax) begin
        oversized_tags++;
        r = '{hdr_byte: 8'd0, last: 1'b1, err: 1'b1, total: 33'd0};
        expected_bytes.push_back(r);
        return;
      end
      id0 = {cls, cons, 5'd0};
      if (tag < dth_pkg::TagShortLim) begin
        hdr.push_back(id0 | tag[7:0]);
      end else begin
        hdr.push_back(id0 | dth_pkg::TagEscape);
        if (tag <= dth_pkg::TagOneByte) begin
          hdr.push_back({1'b0, tag[6:0]});
        end else begin
          // leading base-128 digit carries the continuation bit
          hdr.push_back({1'b1, tag[13:7]});
          hdr.push_back({1'b0, tag[6:0]});
        end
      end
      if (vlen < dth_pkg::LenShortLim) begin
        hdr.push_back(vlen[7:0]);
      end else begin
        if (vlen[31:24] != 8'd0) nlen = 4;
        else if (vlen[23:16] != 8'd0) nlen = 3;
        else if (vlen[15:8] != 8'd0) nlen = 2;
        else nlen = 1;
        hdr.push_back(dth_pkg::LongForm | 8'(nlen));
        for (int i = nlen - 1; i >= 0; i--) hdr.push_back(vlen[8*i +: 8]);
      end
      foreach (hdr[i]) begin
        r.hdr_byte = hdr[i];
        r.last     = (i == hdr.size() - 1);
        r.err      = 1'b0;
        r.total    = r.last ? {1'b0, vlen} + 33'(hdr.size()) : 33'd0;
        expected_bytes.push_back(r);
      end
    endfunction

    function void check_byte(logic [7:0] b, logic last, logic err, logic [32:0] total);
      hdr_byte_t e;
      if (expected_bytes.size() == 0) begin
        $error("header byte 0x%02h arrived with nothing pending", b);
        mismatches++;
        return;
      end
      e = expected_bytes.pop_front();
      bytes_checked++;
      if (b !== e.hdr_byte) begin
        $error("header_byte: expected 0x%02h, got 0x%02h", e.hdr_byte, b);
        mismatches++;
      end
      if (last !== e.last) begin
        $error("last_byte: expected %0b, got %0b", e.last, last);
        mismatches++;
      end
      if (err !== e.err) begin
        $error("tag_error: expected %0b, got %0b", e.err, err);
        mismatches++;
      end
      if (total !== e.total) begin
        $error("total_length: expected %0d, got %0d", e.total, total);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

endpackage

### tb/sv/tb_top.sv
// Top-level bench for the DER header encoder: clock, reset, stimulus, stalls and checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 300;
  localparam int RandomItems = 500;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic [1:0]  in_tag_class     = '0;
  logic        in_constructed   = 1'b0;
  logic [31:0] in_tag_number    = '0;
  logic [31:0] in_value_length  = '0;
  logic        out_stall        = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_header_byte;
  logic        out_last_byte;
  logic        out_tag_error;
  logic [32:0] out_total_length;

  bit          quiet_phase  = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned idle_run     = 0;

  dth_tb_pkg::der_header_scoreboard hdr_sb = new();

  der_tag_length_header_encoder_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_tag_class     (in_tag_class),
    .in_constructed   (in_constructed),
    .in_tag_number    (in_tag_number),
    .in_value_length  (in_value_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_header_byte  (out_header_byte),
    .out_last_byte    (out_last_byte),
    .out_tag_error    (out_tag_error),
    .out_total_length (out_total_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      hdr_sb.check_byte(out_header_byte, out_last_byte, out_tag_error, out_total_length);
    end
  end

  // Watchdog: too many cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Receiver: random stall bursts, one long hold on request, none when quiet
  initial begin
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic send_element(input logic [1:0] cls, input logic cons,
                              input logic [31:0] tag, input logic [31:0] vlen);
    in_valid        <= 1'b1;
    in_tag_class    <= cls;
    in_constructed  <= cons;
    in_tag_number   <= tag;
    in_value_length <= vlen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hdr_sb.note_element(cls, cons, tag, vlen);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_random_element();
    logic [31:0] tag;
    logic [31:0] vlen;
    case ($urandom_range(0, 9))
      0, 1:    tag = $urandom_range(0, 30);
      2, 3:    tag = $urandom_range(31, 127);
      4, 5, 6: tag = $urandom_range(128, 16383);
      7:       tag = $urandom_range(16380, 16390);
      default: tag = $urandom();
    endcase
    case ($urandom_range(0, 5))
      0:       vlen = $urandom_range(0, 127);
      1:       vlen = $urandom_range(128, 255);
      2:       vlen = $urandom_range(256, 65535);
      3:       vlen = $urandom_range(65536, 32'h00ff_ffff);
      4:       vlen = $urandom();
      default: vlen = $urandom() >> $urandom_range(0, 31);
    endcase
    send_element(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), tag, vlen);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hdr_sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short-form and single-byte escaped identifiers, length boundaries
    send_element(2'd0, 1'b0, 32'd0,          32'd0);
    send_element(2'd3, 1'b1, 32'd30,         32'd127);
    send_element(2'd1, 1'b0, 32'd31,         32'd128);
    send_element(2'd2, 1'b1, 32'h7f,         32'd255);
    // mixed tag forms, multi-byte lengths
    send_element(2'd1, 1'b1, 32'h80,         32'd256);
    send_element(2'd2, 1'b0, 32'h3fff,       32'hffff);
    send_element(2'd0, 1'b0, 32'h3fff,       32'h1_0000);
    send_element(2'd3, 1'b0, 32'd100,        32'hff_ffff);
    send_element(2'd1, 1'b1, 32'd5,          32'h100_0000);
    // longest header and largest total
    send_element(2'd3, 1'b1, 32'h3fff,       32'hffff_ffff);
    send_element(2'd2, 1'b1, 32'h2aaa,       32'haaaa_aaaa);
    send_element(2'd1, 1'b0, 32'h1555,       32'h5555_5555);
    // constructed element with a plain value length
    send_element(2'd0, 1'b1, 32'd16,         32'd1000);
    // oversized tags
    send_element(2'd0, 1'b0, 32'h4000,       32'd5);
    send_element(2'd3, 1'b1, 32'hffff_ffff,  32'hffff_ffff);
    send_element(2'd2, 1'b0, 32'h8000_0000,  32'd0);
    wait_drained();

    for (int i = 0; i < RandomItems; i++) begin
      if (i == 150) hold_request = 1'b1;
      if (i == 300) wait_drained();
      if (i == 400) quiet_phase = 1'b1;
      send_random_element();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d elements (%0d with oversized tags), compared %0d header bytes.",
             hdr_sb.elements_seen, hdr_sb.oversized_tags, hdr_sb.bytes_checked);
    $display("Stall bursts on both sides, one long output hold, one full drain pause.");
    if (hdr_sb.mismatches == 0 && hdr_sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
